>>> hw/rtl/rns_pkg.sv
// ----------------------------------------------------------------------------
// rns_pkg
// shared types, constants and the wrap-aware order of the retransmit store
// ----------------------------------------------------------------------------
package rns_pkg;

   localparam int CAPACITY_DEF   = 128;
   localparam int STREAM_W       = 32;
   localparam int SEQ_W          = 16;
   localparam int HANDLE_W       = 16;
   localparam int LEN_W          = 12;
   localparam int PT_W           = 7;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 32;
   localparam logic [PT_W-1:0] PT_RESET = 7'd101;

   localparam logic [CSR_IDX_W-1:0] CSR_RTX_STREAM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RTX_PT     = 1'b1;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_NACK  = 1'b1;

   // one stored descriptor
   typedef struct packed {
      logic [STREAM_W-1:0] stream;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    length;
      logic [LEN_W-1:0]    offset;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic      shift_down;  // every cell takes its upper neighbor (evict)
      logic      insert;      // sorted insert of new entry
      logic      rotate;      // circulate toward cell 0 for walk
      entry_type new_entry;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_OUT,
      ST_DONE
   } state_type;

   // a precedes b in wrap-aware order
   function automatic logic precedes(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return d[SEQ_W-1];
   endfunction

endpackage

>>> hw/rtl/rns_cell.sv
// ----------------------------------------------------------------------------
// rns_cell
// one table slot: holds a descriptor, shifts, inserts and rotates
// ----------------------------------------------------------------------------
module rns_cell
   import rns_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,     // slot index below count
   input  logic         lower_open,   // lower neighbor takes new entry or shifts
   input  logic         upper_open,   // upper neighbor shifts up or is empty
   input  entry_type    lower_entry,
   input  entry_type    upper_entry,
   input  entry_type    wrap_entry,   // value fed in on rotate
   output logic         open_out,     // this slot shifts up on insert
   output entry_type    entry_out
);

   entry_type entry_ff, entry_in;
   logic      moves;

   // slot moves up when occupied, the new entry precedes it and the slot above moves or is empty
   assign moves    = occupied && upper_open && precedes(ctl.new_entry.seq, entry_ff.seq);
   assign open_out = moves;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_down) begin
         entry_in = upper_entry;
      end else if (ctl.rotate) begin
         entry_in = wrap_entry;
      end else if (ctl.insert) begin
         if (moves || !occupied) begin
            if (lower_open) entry_in = lower_entry;
            else entry_in = ctl.new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

>>> hw/rtl/rns_chain.sv
// ----------------------------------------------------------------------------
// rns_chain
// row of cells; cell 0 is the head seen by the walk
// ----------------------------------------------------------------------------
module rns_chain
   import rns_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CNT_W = $clog2(CAPACITY + 1)
)(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [CNT_W-1:0] count,
   output entry_type        head
);

   entry_type ent [CAPACITY];
   logic      open [CAPACITY];

   // every cell rotates; the head wraps to the top occupied slot
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type up, lo, wr;
      logic      lo_open, up_open, occ;
      assign occ     = CNT_W'(g) < count;
      assign up      = (g == CAPACITY - 1) ? ent[g] : ent[(g + 1) % CAPACITY];
      assign lo      = (g == 0) ? ent[g] : ent[(g + CAPACITY - 1) % CAPACITY];
      assign lo_open = (g == 0) ? 1'b0 : open[(g + CAPACITY - 1) % CAPACITY];
      // movers form a run that ends at the top occupied slot
      assign up_open = (g == CAPACITY - 1) ? 1'b1
                       : (CNT_W'(g + 1) >= count || open[(g + 1) % CAPACITY]);
      assign wr      = (CNT_W'(g) == count - 1'b1) ? ent[0] : up;
      rns_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ),
         .lower_open  (lo_open),
         .upper_open  (up_open),
         .lower_entry (lo),
         .upper_entry (up),
         .wrap_entry  (wr),
         .open_out    (open[g]),
         .entry_out   (ent[g])
      );
   end

   assign head = ent[0];

endmodule

>>> hw/rtl/rtp_nack_retransmit_store.sv
// ----------------------------------------------------------------------------
// rtp_nack_retransmit_store
// sorted descriptor table with generic nack walk for retransmission
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  operation, descriptor or nack
//   rsp      out  rsp_valid / rsp_stall  retransmit descriptor
//   csr      in   csr_write              rtx stream id, payload type
// a store when full does an evict shift, then the insert; else only the insert.
// a nack goes through accept, one rotation per occupied slot, a hold per hit
// and a close; the rotation restores order.
// each hit leaves as a beat at the next hit, the final one at the close.
// reset clears count, rtx counter and rtx stream id and presets the payload type
// to 101; the table needs no clear. a stalled result holds the walk at the next hit or at the close.
module rtp_nack_retransmit_store
   import rns_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [STREAM_W-1:0]   req_stream_id,
   input  logic [SEQ_W-1:0]      req_seq_number,
   input  logic [SEQ_W-1:0]      req_lost_mask,
   input  logic [HANDLE_W-1:0]   req_buffer_handle,
   input  logic [LEN_W-1:0]      req_packet_length,
   input  logic [LEN_W-1:0]      req_header_length,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic                  rsp_last,
   output logic [HANDLE_W-1:0]   rsp_out_handle,
   output logic [SEQ_W-1:0]      rsp_original_seq,
   output logic [SEQ_W-1:0]      rsp_rtx_seq,
   output logic [LEN_W-1:0]      rsp_rtx_length,
   output logic [LEN_W-1:0]      rsp_out_header_length,
   output logic [STREAM_W-1:0]   rsp_out_stream_id,
   output logic [PT_W-1:0]       rsp_out_payload_type,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in, left_ff, left_in;
   logic [SEQ_W-1:0]    ctr_ff, ctr_in, pid_ff, pid_in, mask_ff, mask_in;
   logic [STREAM_W-1:0] ssrc_ff, ssrc_in, rtx_sid_ff;
   logic [PT_W-1:0]     rtx_pt_ff;
   logic                going_ff, going_in, nfound_ff, nfound_in;
   logic                pend_ff, pend_in;   // store waiting after evict
   entry_type           pend_entry_ff, pend_entry_in;
   logic                vld_ff, vld_in, fnd_ff, fnd_in, lst_ff, lst_in;
   entry_type           oent_ff, oent_in;
   logic [SEQ_W-1:0]    oseq_ff, oseq_in;
   logic                hold_vld_ff, hold_vld_in;   // hit not yet sent
   entry_type           hold_ent_ff, hold_ent_in;
   logic [SEQ_W-1:0]    hold_seq_ff, hold_seq_in;
   cell_ctl_type        ctl;
   entry_type           head, req_entry;
   logic                accept, hit, beyond, full, out_free;

   assign req_entry = '{stream: req_stream_id, seq: req_seq_number,
                        handle: req_buffer_handle, length: req_packet_length,
                        offset: req_header_length};
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign out_free = !vld_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && !pend_ff && out_free);
   assign accept   = req_valid && !req_stall;
   assign hit      = head.stream == ssrc_ff && head.seq == pid_ff;
   assign beyond   = head.stream == ssrc_ff && head.seq != pid_ff
                     && !precedes(head.seq, pid_ff);

   rns_chain #(.CAPACITY(CAPACITY), .CNT_W(CNT_W)) u_chain (
      .clock (clock), .ctl (ctl), .count (count_ff), .head (head)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_operation == OP_NACK)
            state_in = (count_ff == '0) ? ST_DONE : ST_WALK;
         ST_WALK: if (left_ff == CNT_W'(1) && !(going_ff && hit))
            state_in = ST_DONE;
         else if (going_ff && hit) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = (left_ff == CNT_W'(1)) ? ST_DONE : ST_WALK;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff; left_in = left_ff; ctr_in = ctr_ff;
      pid_in = pid_ff; mask_in = mask_ff; ssrc_in = ssrc_ff;
      going_in = going_ff; nfound_in = nfound_ff;
      pend_in = pend_ff; pend_entry_in = pend_entry_ff;
      vld_in = vld_ff && rsp_stall; fnd_in = fnd_ff; lst_in = lst_ff;
      oent_in = oent_ff; oseq_in = oseq_ff;
      hold_vld_in = hold_vld_ff; hold_ent_in = hold_ent_ff; hold_seq_in = hold_seq_ff;
      ctl = '{shift_down: 1'b0, insert: 1'b0, rotate: 1'b0, new_entry: req_entry};
      unique case (state_ff)
         ST_IDLE: begin
            if (pend_ff) begin
               ctl.insert = 1'b1; ctl.new_entry = pend_entry_ff;
               count_in = count_ff + 1'b1; pend_in = 1'b0;
            end else if (accept && req_operation == OP_STORE) begin
               if (full) begin
                  ctl.shift_down = 1'b1; count_in = count_ff - 1'b1;
                  pend_in = 1'b1; pend_entry_in = req_entry;
               end else begin
                  ctl.insert = 1'b1; count_in = count_ff + 1'b1;
               end
            end else if (accept) begin
               ssrc_in = req_stream_id; pid_in = req_seq_number;
               mask_in = req_lost_mask; going_in = 1'b1; nfound_in = 1'b1;
               left_in = count_ff; hold_vld_in = 1'b0;
            end
         end
         ST_WALK: begin
            if (going_ff && hit) begin
               // emit from ST_OUT; head stays put this cycle
            end else begin
               ctl.rotate = 1'b1; left_in = left_ff - 1'b1;
               if (going_ff && beyond) going_in = 1'b0;
            end
         end
         ST_OUT: if (out_free) begin
            // an earlier hit is now known not to be the final one
            if (hold_vld_ff) begin
               vld_in = 1'b1; fnd_in = 1'b1; lst_in = 1'b0;
               oent_in = hold_ent_ff; oseq_in = hold_seq_ff;
            end
            hold_vld_in = 1'b1; hold_ent_in = head; hold_seq_in = ctr_ff;
            nfound_in = 1'b0; ctr_in = ctr_ff + 1'b1;
            going_in = mask_ff != '0;
            // advance to next set mask bit
            for (int k = SEQ_W - 1; k >= 0; k--) begin
               if (mask_ff[k] && (mask_ff & ((SEQ_W'(1) << k) - 1'b1)) == '0) begin
                  pid_in  = pid_ff + SEQ_W'(k + 1);
                  mask_in = SEQ_W'(mask_ff >> (k + 1));
               end
            end
            ctl.rotate = 1'b1; left_in = left_ff - 1'b1;
         end
         ST_DONE: if (out_free) begin
            if (hold_vld_ff) begin
               vld_in = 1'b1; fnd_in = 1'b1; lst_in = 1'b1;
               oent_in = hold_ent_ff; oseq_in = hold_seq_ff; hold_vld_in = 1'b0;
            end else if (nfound_ff) begin
               vld_in = 1'b1; fnd_in = 1'b0; lst_in = 1'b1;
               oent_in = '0; oseq_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; ctr_ff <= '0; pend_ff <= 1'b0;
         vld_ff <= 1'b0; rtx_sid_ff <= '0; rtx_pt_ff <= PT_RESET;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ctr_ff <= ctr_in;
         pend_ff <= pend_in; vld_ff <= vld_in;
         if (csr_write && csr_index == CSR_RTX_STREAM) rtx_sid_ff <= csr_data;
         if (csr_write && csr_index == CSR_RTX_PT) rtx_pt_ff <= csr_data[PT_W-1:0];
      end
      left_ff <= left_in; pid_ff <= pid_in; mask_ff <= mask_in; ssrc_ff <= ssrc_in;
      going_ff <= going_in; nfound_ff <= nfound_in; pend_entry_ff <= pend_entry_in;
      fnd_ff <= fnd_in; lst_ff <= lst_in; oent_ff <= oent_in; oseq_ff <= oseq_in;
      hold_vld_ff <= hold_vld_in; hold_ent_ff <= hold_ent_in; hold_seq_ff <= hold_seq_in;
   end

   assign rsp_valid             = vld_ff;
   assign rsp_found             = fnd_ff;
   assign rsp_last              = lst_ff;
   assign rsp_out_handle        = oent_ff.handle;
   assign rsp_original_seq      = oent_ff.seq;
   assign rsp_rtx_seq           = oseq_ff;
   assign rsp_rtx_length        = !fnd_ff ? '0 : (&oent_ff.length[LEN_W-1:1])
                                  ? {LEN_W{1'b1}} : oent_ff.length + LEN_W'(2);
   assign rsp_out_header_length = oent_ff.offset;
   assign rsp_out_stream_id     = fnd_ff ? rtx_sid_ff : '0;
   assign rsp_out_payload_type  = fnd_ff ? rtx_pt_ff : '0;

endmodule

>>> hw/rtl/rns_checker.sv
// ----------------------------------------------------------------------------
// rns_checker
// port-level checks of the retransmit store
// ----------------------------------------------------------------------------
module rns_checker
   import rns_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_found,
   input logic rsp_last,
   input logic [SEQ_W-1:0] rsp_rtx_seq
);

   // not-found beat is always the final one
   a_nf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last) else $error("not-found without last");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rtx_seq))
      else $error("stalled result changed");

   // no new item taken mid-nack before the last beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall) else $error("input open mid-walk");

endmodule

bind rtp_nack_retransmit_store rns_checker u_rns_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_found(rsp_found), .rsp_last(rsp_last),
   .rsp_rtx_seq(rsp_rtx_seq)
);
